### src/fpr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpr_pkg: shared types and constants for the fifo page replacement core
// Holds widths, register indexes, status codes and the scan beat struct.
// ---------------------------------------------------------------------------
package fpr_pkg;

    localparam int PAGES_DEF = 256;
    localparam int CNT_W     = 9;
    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int PAGE_W    = 8;

    localparam logic [STAMP_W-1:0] RENORM_AT  = 32'hEE00_0000;
    localparam logic [STAMP_W-1:0] RENORM_SUB = 32'hE000_0000;

    localparam logic [CFG_W-1:0] PAGES_IN_USE_RST  = 9'd256;
    localparam logic [CFG_W-1:0] MAX_COMMITTED_RST = 9'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGES_IN_USE  = 1'b0,
        CFG_MAX_COMMITTED = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_COMMIT   = 1'b0,
        OP_DECOMMIT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_RANGE       = 2'd1,
        ST_WRONG_STATE = 2'd2,
        ST_NO_VICTIM   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_EVICT,
        S_LOAD,
        S_RENORM,
        S_RESULT
    } t_state;

    // one entry read back during the victim scan
    typedef struct packed {
        logic clear;
        logic beat;
        logic cand;
    } t_scan_beat;

endpackage
`default_nettype wire

### src/fpr_victim.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpr_victim: oldest-stamp tracker for the victim scan
// Takes one page entry per beat in ascending index order and keeps the
// candidate with the smallest stamp; ties keep the lower index.
// ---------------------------------------------------------------------------
module fpr_victim #(
    parameter int PAGES = fpr_pkg::PAGES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire fpr_pkg::t_scan_beat              i_beat,
    input  wire logic [$clog2(PAGES)-1:0]         i_idx,
    input  wire logic [fpr_pkg::STAMP_W-1:0]      i_stamp,
    output logic                                  o_found,
    output logic [$clog2(PAGES)-1:0]              o_idx,
    output logic [fpr_pkg::STAMP_W-1:0]           o_stamp
);
    import fpr_pkg::*;

    localparam int ADDR_W = $clog2(PAGES);

    logic               r_found;
    logic [ADDR_W-1:0]  r_idx;
    logic [STAMP_W-1:0] r_stamp;
    logic               w_take;

    assign w_take = i_beat.beat && i_beat.cand && (!r_found || (i_stamp < r_stamp));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_beat.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_idx   <= i_idx;
            r_stamp <= i_stamp;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_stamp = r_stamp;

endmodule
`default_nettype wire

### src/fifo_page_replacement_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fifo_page_replacement_core: fifo page replacement controller
// Per-page resident flag and load stamp in one synchronous ram; commits
// evict the oldest resident page when the resident limit is reached.
//
//   channel  beat when            payload
//   -------  -------------------  ----------------------------------------
//   in       valid & !stall       operation, page_index
//   out      valid & !stall       status, evicted_valid, evicted_page,
//                                 committed_count
//   cfg      valid & ready        index, data (9 bits)
//
// an out of range page goes straight to the result; other items first read
// the page entry; a commit that evicts scans the first limit ram entries for
// the oldest resident page and evicts it; a load at the renormalization
// threshold adds a pass over the same entries (limit = min(pages_in_use,
// PAGES)). after reset a clearing pass zeroes the ram; in stalls until it
// ends. an input beat is taken while a result waits in the output register;
// the next result waits for out stall to drop.
// ---------------------------------------------------------------------------
module fifo_page_replacement_core #(
    parameter int PAGES = fpr_pkg::PAGES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // item input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_operation,
    input  wire logic [fpr_pkg::PAGE_W-1:0]         i_page_index,
    // result output
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [1:0]                              o_status,
    output logic                                    o_evicted_valid,
    output logic [fpr_pkg::PAGE_W-1:0]              o_evicted_page,
    output logic [fpr_pkg::CNT_W-1:0]               o_committed_count,
    // configuration writes
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [fpr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [fpr_pkg::CFG_W-1:0]          i_cfg_data
);
    import fpr_pkg::*;

    localparam int ADDR_W = $clog2(PAGES);
    localparam int LIM_W  = ($clog2(PAGES + 1) > CFG_W) ? $clog2(PAGES + 1) : CFG_W;
    localparam int MEM_W  = STAMP_W + 1;

    // configuration
    logic [CFG_W-1:0] r_pages_in_use;
    logic [CFG_W-1:0] r_max_committed;

    // control
    t_state             r_state, n_state;
    logic [LIM_W-1:0]   r_scan, n_scan;
    logic               r_rd_v;
    logic [ADDR_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [STAMP_W-1:0] r_load_counter, n_load_counter;
    logic               r_out_valid;

    // item payload
    logic [ADDR_W-1:0]  r_page, n_page;
    t_op                r_op, n_op;
    t_status            r_status, n_status;
    logic               r_ev_valid, n_ev_valid;
    logic [PAGE_W-1:0]  r_ev_page, n_ev_page;

    // page ram
    logic [MEM_W-1:0]   mem_page [PAGES];
    logic [MEM_W-1:0]   r_mem_q;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [MEM_W-1:0]   w_wdata;
    logic [ADDR_W-1:0]  w_raddr;

    logic [LIM_W-1:0]   w_limit;
    logic [LIM_W-1:0]   w_page_ext;
    logic               w_issue;
    logic               w_out_free;
    logic               w_q_res;
    logic [STAMP_W-1:0] w_q_stamp;
    logic [STAMP_W-1:0] w_next_stamp;
    t_scan_beat         w_beat;
    logic               w_found;
    logic [ADDR_W-1:0]  w_best_idx;
    logic [STAMP_W-1:0] w_best_stamp;

    assign w_limit = (LIM_W'(r_pages_in_use) < LIM_W'(PAGES)) ?
                     LIM_W'(r_pages_in_use) : LIM_W'(PAGES);
    assign w_page_ext   = LIM_W'(i_page_index);
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_q_res      = r_mem_q[STAMP_W];
    assign w_q_stamp    = r_mem_q[STAMP_W-1:0];
    assign w_next_stamp = r_load_counter + 32'd1;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_in_use  <= PAGES_IN_USE_RST;
            r_max_committed <= MAX_COMMITTED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PAGES_IN_USE:  r_pages_in_use  <= i_cfg_data;
                CFG_MAX_COMMITTED: r_max_committed <= i_cfg_data;
            endcase
        end
    end

    // page ram, one write and one read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_page[w_waddr] <= w_wdata;
        end
        r_mem_q <= mem_page[w_raddr];
    end

    fpr_victim #(
        .PAGES (PAGES)
    ) u_victim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (w_beat),
        .i_idx   (r_rd_idx),
        .i_stamp (w_q_stamp),
        .o_found (w_found),
        .o_idx   (w_best_idx),
        .o_stamp (w_best_stamp)
    );

    always_comb begin
        n_state        = r_state;
        n_scan         = r_scan;
        n_count        = r_count;
        n_load_counter = r_load_counter;
        n_page         = r_page;
        n_op           = r_op;
        n_status       = r_status;
        n_ev_valid     = r_ev_valid;
        n_ev_page      = r_ev_page;
        w_we           = 1'b0;
        w_waddr        = r_page;
        w_wdata        = '0;
        w_raddr        = ADDR_W'(i_page_index);
        w_issue        = 1'b0;
        w_beat.clear   = 1'b0;
        w_beat.beat    = r_rd_v && (r_state == S_SCAN);
        w_beat.cand    = w_q_res && (r_rd_idx != r_page);

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_scan[ADDR_W-1:0];
                n_scan  = r_scan + 1'b1;
                if (r_scan == LIM_W'(PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_page     = ADDR_W'(i_page_index);
                    n_op       = t_op'(i_operation);
                    n_ev_valid = 1'b0;
                    n_ev_page  = '0;
                    n_status   = ST_DONE;
                    if (w_page_ext >= w_limit) begin
                        n_status = ST_RANGE;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                unique case (r_op)
                    OP_COMMIT: begin
                        if (w_q_res) begin
                            n_status = ST_WRONG_STATE;
                            n_state  = S_RESULT;
                        end else if (r_count >= r_max_committed) begin
                            n_scan       = '0;
                            w_beat.clear = 1'b1;
                            n_state      = S_SCAN;
                        end else begin
                            n_state = S_LOAD;
                        end
                    end
                    OP_DECOMMIT: begin
                        if (!w_q_res) begin
                            n_status = ST_WRONG_STATE;
                        end else begin
                            w_we    = 1'b1;
                            w_wdata = {1'b0, w_q_stamp};
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_SCAN: begin
                w_raddr = r_scan[ADDR_W-1:0];
                w_issue = (r_scan < w_limit);
                if (w_issue) begin
                    n_scan = r_scan + 1'b1;
                end else if (!r_rd_v) begin
                    if (w_found) begin
                        n_state = S_EVICT;
                    end else begin
                        n_status = ST_NO_VICTIM;
                        n_state  = S_RESULT;
                    end
                end
            end
            S_EVICT: begin
                w_we       = 1'b1;
                w_waddr    = w_best_idx;
                w_wdata    = {1'b0, w_best_stamp};
                n_count    = r_count - 1'b1;
                n_ev_valid = 1'b1;
                n_ev_page  = PAGE_W'(w_best_idx);
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                w_we    = 1'b1;
                w_wdata = {1'b1, w_next_stamp};
                if (r_count != '1) begin
                    n_count = r_count + 1'b1;
                end
                if (w_next_stamp >= RENORM_AT) begin
                    n_load_counter = w_next_stamp - RENORM_SUB;
                    n_scan         = '0;
                    n_state        = S_RENORM;
                end else begin
                    n_load_counter = w_next_stamp;
                    n_state        = S_RESULT;
                end
            end
            S_RENORM: begin
                // read one entry ahead, write back the one returned
                w_raddr = r_scan[ADDR_W-1:0];
                w_issue = (r_scan < w_limit);
                if (r_rd_v && w_q_res && (w_q_stamp > RENORM_SUB)) begin
                    w_we    = 1'b1;
                    w_waddr = r_rd_idx;
                    w_wdata = {1'b1, w_q_stamp - RENORM_SUB};
                end
                if (w_issue) begin
                    n_scan = r_scan + 1'b1;
                end else if (!r_rd_v) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_scan         <= '0;
            r_rd_v         <= 1'b0;
            r_count        <= '0;
            r_load_counter <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_scan         <= n_scan;
            r_rd_v         <= w_issue;
            r_count        <= n_count;
            r_load_counter <= n_load_counter;
            if ((r_state == S_RESULT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= r_scan[ADDR_W-1:0];
        r_page     <= n_page;
        r_op       <= n_op;
        r_status   <= n_status;
        r_ev_valid <= n_ev_valid;
        r_ev_page  <= n_ev_page;
        if ((r_state == S_RESULT) && w_out_free) begin
            o_status          <= r_status;
            o_evicted_valid   <= r_ev_valid;
            o_evicted_page    <= r_ev_page;
            o_committed_count <= r_count;
        end
    end

    // resident count only moves on a check, eviction or load
    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ($past(r_state) == S_CHECK || $past(r_state) == S_EVICT ||
             $past(r_state) == S_LOAD))
        else $error("resident count changed outside an update step");

    a_evict_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |-> w_found)
        else $error("eviction without a victim");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state != S_IDLE && r_state != S_RESULT))
        else $error("page ram written while no item is in work");

    a_evict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && r_ev_valid) |-> (r_status == ST_DONE))
        else $error("eviction reported with a failing status");

endmodule
`default_nettype wire
